// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the cave automaton RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies c in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed: a implies c");

// Check that a implies c in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed: a implies c next cycle");

`endif

// ===== rtl/cas_pkg.sv =====
// Types and constants for the cave automaton stencil step.
// Used by cave_automaton_stencil_step; depends on nothing.
`default_nettype none

package cas_pkg;

  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 11;
  localparam int BirthMinW   = 4;
  localparam int DeathMaxW   = 4;
  localparam int RowLengthW  = 9;
  localparam int FrameRowsW  = 11;
  localparam int CountW      = 4;

  localparam logic [BirthMinW-1:0]  BirthMinReset  = 4'd6;
  localparam logic [DeathMaxW-1:0]  DeathMaxReset  = 4'd3;
  localparam logic [RowLengthW-1:0] RowLengthReset = 9'd200;
  localparam logic [FrameRowsW-1:0] FrameRowsReset = 11'd120;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIRTH_MIN  = 2'd0,
    CFG_DEATH_MAX  = 2'd1,
    CFG_ROW_LENGTH = 2'd2,
    CFG_FRAME_ROWS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic cell_alive;
    logic pad;
  } in_item_t;

  typedef struct packed {
    logic              next_alive;
    logic [CountW-1:0] neighbour_count;
    logic              row_end;
    logic              frame_end;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/cas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the line buffers; depends on nothing.
`default_nettype none

module cas_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/cave_automaton_stencil_step.sv =====
// Cave automaton stencil step: one smoothing generation over a raster cell stream.
// Depends on cas_pkg, cas_ram and assert_macros.svh.
//
// Takes one item per clock unless the reset clear or a stalled output holds it; an item
// is registered in s1, then its result (if any) in the output register. The result for
// a cell appears with the item clamped row_length+1 places behind it. The two line
// buffers share one 2-bit RAM, read when an item is accepted and written back when it
// leaves s1, with a bypass when two items in a row hit the same column. After reset the
// RAM is cleared one column per cycle, input stalled; configuration writes are taken.
`default_nettype none

`include "assert_macros.svh"

module cave_automaton_stencil_step #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cas_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [cas_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire cas_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output cas_pkg::out_item_t                  out_item_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 2);
  localparam int WXW = (WW > cas_pkg::RowLengthW) ? WW : cas_pkg::RowLengthW;
  localparam int HXW = (HW > cas_pkg::FrameRowsW) ? HW : cas_pkg::FrameRowsW;
  localparam int CNT = cas_pkg::CountW;

  // configuration
  logic [cas_pkg::BirthMinW-1:0]  birth_min_q;
  logic [cas_pkg::DeathMaxW-1:0]  death_max_q;
  logic [cas_pkg::RowLengthW-1:0] row_length_q;
  logic [cas_pkg::FrameRowsW-1:0] frame_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_min_q  <= cas_pkg::BirthMinReset;
      death_max_q  <= cas_pkg::DeathMaxReset;
      row_length_q <= cas_pkg::RowLengthReset;
      frame_rows_q <= cas_pkg::FrameRowsReset;
    end else if (cfg_we_i) begin
      unique case (cas_pkg::cfg_idx_e'(cfg_index_i))
        cas_pkg::CFG_BIRTH_MIN:  birth_min_q  <= cfg_data_i[cas_pkg::BirthMinW-1:0];
        cas_pkg::CFG_DEATH_MAX:  death_max_q  <= cfg_data_i[cas_pkg::DeathMaxW-1:0];
        cas_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_data_i[cas_pkg::RowLengthW-1:0];
        cas_pkg::CFG_FRAME_ROWS: frame_rows_q <= cfg_data_i[cas_pkg::FrameRowsW-1:0];
      endcase
    end
  end

  // clamped grid size
  logic [WXW-1:0] wx;
  logic [HXW-1:0] hx;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;

  always_comb begin
    wx = WXW'(row_length_q);
    hx = HXW'(frame_rows_q);
    if (wx == '0) begin
      wx = WXW'(1);
    end else if (wx > WXW'(MAX_WIDTH)) begin
      wx = WXW'(MAX_WIDTH);
    end
    if (hx == '0) begin
      hx = HXW'(1);
    end else if (hx > HXW'(MAX_HEIGHT)) begin
      hx = HXW'(MAX_HEIGHT);
    end
    w = WW'(wx);
    h = HW'(hx);
  end

  // control and pipeline registers
  logic          clr_active_q;
  logic [CW-1:0] clr_addr_q;
  logic [CW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic          s1_valid_q;
  logic          s1_cell_q;
  logic [CW-1:0] s1_col_q;
  logic [HW-1:0] s1_row_q;
  logic          fwd_q;
  logic [1:0]    fwd_data_q;
  logic [8:0]    win_q, win_d;
  logic          out_valid_q;
  cas_pkg::out_item_t out_q;

  logic       accept;
  logic       s1_fire;
  logic       res_valid;
  logic       out_free;
  logic [1:0] rd_data;
  logic [1:0] entry;
  logic [1:0] wr_data;
  logic       top, mid;
  cas_pkg::out_item_t res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!res_valid || out_free);
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_fire);
  assign accept     = in_valid_i && !in_stall_o;

  // raster position of the next item
  logic [WW-1:0] col_inc;

  always_comb begin
    col_inc = WW'(col_q) + WW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (row_q >= h + HW'(1) && col_q == '0) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= w) begin
      col_d = '0;
      row_d = row_q + HW'(1);
    end else begin
      col_d = CW'(col_inc);
    end
  end

  // line buffer: bit 0 two rows back, bit 1 one row back
  assign entry   = fwd_q ? fwd_data_q : rd_data;
  assign top     = entry[0];
  assign mid     = entry[1];
  assign wr_data = {s1_cell_q, mid};

  cas_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (clr_active_q || s1_fire),
    .waddr_i(clr_active_q ? clr_addr_q : s1_col_q),
    .wdata_i(clr_active_q ? 2'b00 : wr_data),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(rd_data)
  );

  // stencil evaluation
  logic          col0;
  logic [HW-1:0] off;
  logic [HW-1:0] r;
  logic [CW-1:0] c;
  logic          top_ok, bot_ok, left_ok, right_ok;
  logic [2:0]    lft, ctr, rgt;
  logic [CNT-1:0] count;
  logic          self_bit;
  logic          next_bit;

  always_comb begin
    col0  = (s1_col_q == '0);
    win_d = col0 ? win_q : {s1_cell_q, mid, top, win_q[8:3]};
    off   = col0 ? HW'(2) : HW'(1);
    r     = s1_row_q - off;
    c     = col0 ? CW'(w - WW'(1)) : s1_col_q - CW'(1);
    res_valid = (s1_row_q >= off) && (r < h) && (WW'(c) < w);
    top_ok   = (r != '0);
    bot_ok   = (r + HW'(1)) < h;
    left_ok  = (c != '0);
    right_ok = (WW'(c) + WW'(1)) < w;
    lft = col0 ? win_d[5:3] : win_d[2:0];
    ctr = col0 ? win_d[8:6] : win_d[5:3];
    rgt = col0 ? 3'b000 : win_d[8:6];
    count = CNT'(lft[0] & top_ok & left_ok) + CNT'(lft[1] & left_ok)
          + CNT'(lft[2] & bot_ok & left_ok) + CNT'(ctr[0] & top_ok)
          + CNT'(ctr[2] & bot_ok) + CNT'(rgt[0] & top_ok & right_ok)
          + CNT'(rgt[1] & right_ok) + CNT'(rgt[2] & bot_ok & right_ok);
    self_bit = ctr[1];
    priority if (!self_bit && count >= CNT'(birth_min_q)) begin
      next_bit = 1'b1;
    end else if (self_bit && count <= CNT'(death_max_q)) begin
      next_bit = 1'b0;
    end else begin
      next_bit = self_bit;
    end
    res.next_alive      = next_bit;
    res.neighbour_count = count;
    res.row_end         = (WW'(c) == w - WW'(1));
    res.frame_end       = res.row_end && (r == h - HW'(1));
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      col_q        <= '0;
      row_q        <= '0;
      s1_valid_q   <= 1'b0;
      fwd_q        <= 1'b0;
      win_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + CW'(1);
        if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && (s1_col_q == col_q);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        win_q <= win_d;
      end
      if (s1_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cell_q  <= in_item_i.cell_alive && !in_item_i.pad;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      fwd_data_q <= wr_data;
    end
    if (s1_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_IMPLIES(a_clear_empty, clk_i, rst_ni, clr_active_q, !s1_valid_q && !out_valid_q)
  `ASSERT_IMPLIES(a_frame_row_end, clk_i, rst_ni, out_valid_q && out_q.frame_end, out_q.row_end)
  `ASSERT_IMPLIES(a_count_range, clk_i, rst_ni, out_valid_q, out_q.neighbour_count <= CNT'(8))
  `ASSERT_NEXT(a_result_lands, clk_i, rst_ni, s1_fire && res_valid, out_valid_q)

endmodule

`default_nettype wire

// ===== sim/cave_automaton_stencil_step_test.sv =====
// Testbench for cave_automaton_stencil_step: raster cell frames in, smoothed cells checked out.
// Holds its own line-buffer predictor of the generation step; depends on cas_pkg and the RTL.
`default_nettype none

module cave_automaton_stencil_step_test;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 1024;
  localparam int CycleLimit = 1000000;
  localparam int Settle     = 16;
  localparam int DataW      = cas_pkg::CfgDataW;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [cas_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [DataW-1:0]             cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  cas_pkg::in_item_t            in_item_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  cas_pkg::out_item_t           out_item_o;

  cave_automaton_stencil_step #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // predictor state
  logic [cas_pkg::BirthMinW-1:0]  birth_min  = cas_pkg::BirthMinReset;
  logic [cas_pkg::DeathMaxW-1:0]  death_max  = cas_pkg::DeathMaxReset;
  logic [cas_pkg::RowLengthW-1:0] row_length = cas_pkg::RowLengthReset;
  logic [cas_pkg::FrameRowsW-1:0] frame_rows = cas_pkg::FrameRowsReset;
  bit                             upper_row [MaxWidth];
  bit                             middle_row[MaxWidth];
  logic [8:0]                     window = '0;
  int                             pos_col = 0;
  int                             pos_row = 0;

  cas_pkg::out_item_t pending_cells[$];
  bit                 next_generation[$];
  cas_pkg::in_item_t  frame_cells[$];

  int mismatches  = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  cas_pkg::out_item_t want;

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int grid_width();
    int w;
    w = row_length;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int grid_height();
    int h;
    h = frame_rows;
    if (h < 1) h = 1;
    if (h > MaxHeight) h = MaxHeight;
    return h;
  endfunction

  task automatic step_stencil(input cas_pkg::in_item_t it);
    int   w, h, r, c, jc, cnt, nr, nc, dr, dc, ncol, nrow;
    logic cur_alive, up_bit, mid_bit, own_alive, born_state;
    cas_pkg::out_item_t res;
    w = grid_width();
    h = grid_height();
    cur_alive = it.pad ? 1'b0 : it.cell_alive;
    up_bit = 1'b0;
    mid_bit = 1'b0;
    if (pos_col < MaxWidth) begin
      up_bit = upper_row[pos_col];
      mid_bit = middle_row[pos_col];
      upper_row[pos_col] = mid_bit;
      middle_row[pos_col] = cur_alive;
    end
    if (pos_col == 0) begin
      r = pos_row - 2;
      c = w - 1;
      jc = 2;
    end else begin
      window = {cur_alive, mid_bit, up_bit, window[8:3]};
      r = pos_row - 1;
      c = pos_col - 1;
      jc = 1;
    end
    if (r >= 0 && r < h && c >= 0 && c < w) begin
      own_alive = window[3*jc+1];
      cnt = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          nr = r + dr;
          nc = c + dc;
          if (!(dr == 0 && dc == 0) && nr >= 0 && nr < h && nc >= 0 && nc < w)
            cnt += window[3*(jc+dc)+1+dr];
        end
      end
      if (!own_alive && cnt >= birth_min) born_state = 1'b1;
      else if (own_alive && cnt <= death_max) born_state = 1'b0;
      else born_state = own_alive;
      res.next_alive = born_state;
      res.neighbour_count = cnt[cas_pkg::CountW-1:0];
      res.row_end = (c == w - 1);
      res.frame_end = (c == w - 1) && (r == h - 1);
      pending_cells.push_back(res);
      next_generation.push_back(born_state);
    end
    if (pos_col + 1 >= w) begin
      ncol = 0;
      nrow = pos_row + 1;
    end else begin
      ncol = pos_col + 1;
      nrow = pos_row;
    end
    if (pos_row >= h + 1 && pos_col == 0) begin
      ncol = 0;
      nrow = 0;
    end
    pos_col = ncol;
    pos_row = nrow;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: alive %0b count %0d row_end %0b frame_end %0b",
                     out_item_o.next_alive, out_item_o.neighbour_count,
                     out_item_o.row_end, out_item_o.frame_end);
        end else begin
          want = pending_cells.pop_front();
          if (out_item_o.next_alive !== want.next_alive ||
              out_item_o.neighbour_count !== want.neighbour_count ||
              out_item_o.row_end !== want.row_end ||
              out_item_o.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: expected alive %0b count %0d row_end %0b frame_end %0b,",
                     want.next_alive, want.neighbour_count, want.row_end, want.frame_end);
              $display(" got alive %0b count %0d row_end %0b frame_end %0b",
                       out_item_o.next_alive, out_item_o.neighbour_count,
                       out_item_o.row_end, out_item_o.frame_end);
            end
          end
        end
        stall_left = rx_quiet ? 0 : $urandom_range(0, 12);
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic send_item(input logic alive_bit, input logic pad_bit);
    int gap;
    cas_pkg::in_item_t it;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    it.cell_alive = alive_bit;
    it.pad = pad_bit;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    step_stencil(it);
    items_sent++;
  endtask

  task automatic drain_results(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input cas_pkg::cfg_idx_e idx, input logic [DataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    unique case (idx)
      cas_pkg::CFG_BIRTH_MIN:  birth_min = data[cas_pkg::BirthMinW-1:0];
      cas_pkg::CFG_DEATH_MAX:  death_max = data[cas_pkg::DeathMaxW-1:0];
      cas_pkg::CFG_ROW_LENGTH: row_length = data[cas_pkg::RowLengthW-1:0];
      cas_pkg::CFG_FRAME_ROWS: frame_rows = data[cas_pkg::FrameRowsW-1:0];
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic fill_frame(input int density, input bit noisy);
    cas_pkg::in_item_t it;
    frame_cells.delete();
    repeat (grid_width() * grid_height()) begin
      it.cell_alive = ($urandom_range(0, 99) < density);
      it.pad = noisy && ($urandom_range(0, 9) == 0);
      frame_cells.push_back(it);
    end
  endtask

  task automatic send_frame();
    foreach (frame_cells[i]) send_item(frame_cells[i].cell_alive, frame_cells[i].pad);
    repeat (grid_width() + 1) send_item(1'($urandom_range(0, 1)), 1'b1);
  endtask

  // flush with pad items until the position counters are back at a frame start
  task automatic sync_frame();
    while (!(pos_col == 0 && pos_row == 0)) send_item(1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic test_reset_defaults();
    repeat (5) send_item(1'($urandom_range(0, 1)), 1'b0);
    drain_results(Settle);
    write_reg(cas_pkg::CFG_ROW_LENGTH, 11'd3);
    write_reg(cas_pkg::CFG_FRAME_ROWS, 11'd2);
    write_reg(cas_pkg::CFG_BIRTH_MIN, 11'd3);
    write_reg(cas_pkg::CFG_DEATH_MAX, 11'd2);
    repeat (10) send_item(1'($urandom_range(0, 1)), 1'b0);
    sync_frame();
  endtask

  task automatic test_directed();
    cas_pkg::in_item_t it;
    drain_results(Settle);
    write_reg(cas_pkg::CFG_ROW_LENGTH, 11'd3);
    write_reg(cas_pkg::CFG_FRAME_ROWS, 11'd3);
    write_reg(cas_pkg::CFG_BIRTH_MIN, 11'd8);
    write_reg(cas_pkg::CFG_DEATH_MAX, 11'd0);
    frame_cells.delete();
    it.cell_alive = 1'b1;
    it.pad = 1'b0;
    repeat (9) frame_cells.push_back(it);
    send_frame();
    drain_results(Settle);
    write_reg(cas_pkg::CFG_BIRTH_MIN, 11'd0);
    write_reg(cas_pkg::CFG_DEATH_MAX, 11'd8);
    frame_cells.delete();
    for (int i = 0; i < 9; i++) begin
      it.cell_alive = i[0];
      it.pad = (i == 4);
      if (i == 4) it.cell_alive = 1'b1;
      frame_cells.push_back(it);
    end
    send_frame();
  endtask

  task automatic test_size_extremes();
    int rls[5] = '{0, 511, 256, 1, 2};
    int frs[5] = '{0, 1, 2, 2047, 1};
    for (int i = 0; i < 5; i++) begin
      drain_results(Settle);
      write_reg(cas_pkg::CFG_ROW_LENGTH, DataW'(rls[i]));
      write_reg(cas_pkg::CFG_FRAME_ROWS, DataW'(frs[i]));
      write_reg(cas_pkg::CFG_BIRTH_MIN, DataW'($urandom_range(0, 8)));
      write_reg(cas_pkg::CFG_DEATH_MAX, DataW'($urandom_range(0, 8)));
      tx_quiet = (i != 0) && ($urandom_range(0, 1) == 0);
      rx_quiet = (i != 0) && ($urandom_range(0, 1) == 0);
      fill_frame($urandom_range(20, 80), 1'b0);
      send_frame();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_generations();
    cas_pkg::in_item_t it;
    sync_frame();
    drain_results(Settle);
    write_reg(cas_pkg::CFG_BIRTH_MIN, 11'd5);
    write_reg(cas_pkg::CFG_DEATH_MAX, 11'd3);
    write_reg(cas_pkg::CFG_ROW_LENGTH, 11'h607);
    write_reg(cas_pkg::CFG_FRAME_ROWS, 11'd5);
    fill_frame(45, 1'b0);
    repeat (4) begin
      next_generation.delete();
      send_frame();
      frame_cells.delete();
      foreach (next_generation[i]) begin
        it.cell_alive = next_generation[i];
        it.pad = 1'b0;
        frame_cells.push_back(it);
      end
    end
  endtask

  task automatic test_random();
    int kind, burst_len;
    items_sent = 0;
    while (items_sent < 900) begin
      drain_results(Settle);
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 7) == 0)
          write_reg(cas_pkg::CFG_BIRTH_MIN, DataW'($urandom_range(0, 2047)));
        else
          write_reg(cas_pkg::CFG_BIRTH_MIN, DataW'($urandom_range(0, 8)));
      end
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 7) == 0)
          write_reg(cas_pkg::CFG_DEATH_MAX, DataW'($urandom_range(0, 2047)));
        else
          write_reg(cas_pkg::CFG_DEATH_MAX, DataW'($urandom_range(0, 8)));
      end
      if ($urandom_range(0, 1) == 0)
        write_reg(cas_pkg::CFG_ROW_LENGTH,
                  DataW'(($urandom_range(0, 3) << cas_pkg::RowLengthW) |
                         ($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 10))));
      if ($urandom_range(0, 1) == 0)
        write_reg(cas_pkg::CFG_FRAME_ROWS,
                  DataW'($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 6)));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          burst_len = $urandom_range(1, grid_width() * grid_height() + grid_width());
          repeat (burst_len)
            send_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
          if ($urandom_range(0, 2) == 0) drain_results(0);
          sync_frame();
        end else begin
          fill_frame($urandom_range(0, 100), kind == 1);
          send_frame();
        end
        if ($urandom_range(0, 5) == 0) drain_results(0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_size_extremes();
    test_generations();
    test_random();
    drain_results(Settle);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/cas_pkg.sv
rtl/cas_ram.sv
rtl/cave_automaton_stencil_step.sv
sim/cave_automaton_stencil_step_test.sv
